// ===== hw/rtl/software_timer_bank_macros.svh =====
// assertion macros used by the checker file
// depends on a clk and an arst_n signal in the scope of each use
`ifndef SOFTWARE_TIMER_BANK_MACROS_SVH
`define SOFTWARE_TIMER_BANK_MACROS_SVH

// checked only out of reset
`define STB_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, also during reset
`define STB_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/stb_pkg.sv =====
// shared constants, codes and payload types of the software timer bank
// no dependencies
package stb_pkg;

	localparam int CHANNELS   = 16;
	localparam int COUNT_BITS = 16;
	localparam int CH_BITS    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CNT_W      = $clog2(CHANNELS + 1);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	localparam logic [2:0] OP_TICK     = 3'd0;
	localparam logic [2:0] OP_ENABLE   = 3'd1;
	localparam logic [2:0] OP_DISABLE  = 3'd2;
	localparam logic [2:0] OP_CLEAR    = 3'd3;
	localparam logic [2:0] OP_READ     = 3'd4;
	localparam logic [2:0] OP_WRITE    = 3'd5;
	localparam logic [2:0] OP_ALLOCATE = 3'd6;
	localparam logic [2:0] OP_UPTIME   = 3'd7;

	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_BAD_CHANNEL = 2'd1;
	localparam logic [1:0] ST_NO_FREE     = 2'd2;

	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  channel;
		logic [15:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] data;
	} rsp_t;

	typedef struct packed {
		logic                  rd_en;
		logic [CH_BITS-1:0]    rd_addr;
		logic                  wr_en;
		logic [CH_BITS-1:0]    wr_addr;
		logic [COUNT_BITS-1:0] wr_data;
	} mem_req_t;

endpackage

// ===== hw/rtl/software_timer_bank.sv =====
// software timer bank: 16 saturating 16-bit channel counters in one memory plus 32-bit uptime
// enable, disable, clear, write, uptime and bad channel go from accept straight to the done state;
// read passes a read state, allocate a search of the allocation flags, tick a walk of all channels
// one request at a time, the next is taken once the response moves to the output register;
// the tick walk and an allocate that finds no free channel take the longest
// async active-low reset clears all counters, enables, allocations and the uptime
module software_timer_bank (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  stb_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output stb_pkg::rsp_t rsp
);

	stb_pkg::mem_req_t              mem;
	logic [stb_pkg::COUNT_BITS-1:0] rd_data;
	logic                           res_valid;
	logic                           res_ready;
	stb_pkg::rsp_t                  res;

	logic                           rsp_valid_q;
	stb_pkg::rsp_t                  rsp_q;

	// sequencer: op decode, enable and allocation flags, uptime, tick walk
	stb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.mem       (mem),
		.rd_data   (rd_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// counter memory with registered read
	stb_count_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.mem     (mem),
		.rd_data (rd_data)
	);

	// output register: lets the sequencer take the next request while
	// the previous response still waits for the consumer
	assign res_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else if (res_valid && res_ready) begin
			rsp_valid_q <= 1'b1;
			rsp_q       <= res;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== hw/rtl/stb_count_store.sv =====
// counter memory of the timer bank: one write and one registered read a cycle
// per-entry valid bits make never-written counters read as zero; uses stb_pkg
module stb_count_store (
	input  logic                           clk,
	input  logic                           arst_n,
	input  stb_pkg::mem_req_t              mem,
	output logic [stb_pkg::COUNT_BITS-1:0] rd_data
);

	logic [stb_pkg::COUNT_BITS-1:0] cnt_mem [stb_pkg::CHANNELS];
	logic [stb_pkg::CHANNELS-1:0]   vld_q;
	logic [stb_pkg::COUNT_BITS-1:0] rd_data_q;
	logic                           rd_vld_q;

	always_ff @(posedge clk) begin
		if (mem.wr_en) begin
			cnt_mem[mem.wr_addr] <= mem.wr_data;
		end
		if (mem.rd_en) begin
			rd_data_q <= cnt_mem[mem.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (mem.wr_en) begin
				vld_q[mem.wr_addr] <= 1'b1;
			end
			if (mem.rd_en) begin
				rd_vld_q <= vld_q[mem.rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

// ===== hw/rtl/stb_ctrl.sv =====
// request sequencer of the timer bank: decodes ops, walks the counter memory
// on a tick, searches for a free channel on allocate; uses stb_pkg
module stb_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  stb_pkg::req_t                  req,
	output stb_pkg::mem_req_t              mem,
	input  logic [stb_pkg::COUNT_BITS-1:0] rd_data,
	output logic                           res_valid,
	input  logic                           res_ready,
	output stb_pkg::rsp_t                  res
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_TICK  = 3'd1;
	localparam logic [2:0] S_ALLOC = 3'd2;
	localparam logic [2:0] S_READ  = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	localparam logic [stb_pkg::CNT_W-1:0] CNT_END = stb_pkg::CNT_W'(stb_pkg::CHANNELS);

	logic [2:0]                      state_q;
	logic [stb_pkg::CNT_W-1:0]       cnt_q;
	logic [stb_pkg::CHANNELS-1:0]    enabled_q;
	logic [stb_pkg::CHANNELS-1:0]    allocated_q;
	logic [31:0]                     uptime_q;
	stb_pkg::rsp_t                   res_q;
	logic                            wr_go_s1;
	logic [stb_pkg::CH_BITS-1:0]     wr_idx_s1;

	logic                            accept;
	logic                            ch_ok;
	logic [stb_pkg::CH_BITS-1:0]     ch_idx;
	logic [stb_pkg::CH_BITS-1:0]     cnt_idx;
	logic                            cnt_end;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign ch_ok     = (req.channel < 8'(stb_pkg::CHANNELS));
	assign ch_idx    = req.channel[stb_pkg::CH_BITS-1:0];
	assign cnt_idx   = cnt_q[stb_pkg::CH_BITS-1:0];
	assign cnt_end   = (cnt_q == CNT_END);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	// memory port: single-channel access at accept, read-increment-write on tick
	always_comb begin
		mem = '0;
		if (accept && ch_ok) begin
			unique case (req.op)
				stb_pkg::OP_READ: begin
					mem.rd_en   = 1'b1;
					mem.rd_addr = ch_idx;
				end
				stb_pkg::OP_CLEAR: begin
					mem.wr_en   = 1'b1;
					mem.wr_addr = ch_idx;
				end
				stb_pkg::OP_WRITE: begin
					mem.wr_en   = 1'b1;
					mem.wr_addr = ch_idx;
					mem.wr_data = stb_pkg::COUNT_BITS'(req.value);
				end
				default: ;
			endcase
		end
		if (state_q == S_TICK) begin
			if (!cnt_end) begin
				mem.rd_en   = 1'b1;
				mem.rd_addr = cnt_idx;
			end
			if (wr_go_s1 && enabled_q[wr_idx_s1] && (rd_data != stb_pkg::COUNT_MAX)) begin
				mem.wr_en   = 1'b1;
				mem.wr_addr = wr_idx_s1;
				mem.wr_data = rd_data + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			enabled_q   <= '0;
			allocated_q <= '0;
			uptime_q    <= '0;
			res_q       <= '0;
			wr_go_s1    <= 1'b0;
			wr_idx_s1   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (req.op) inside
							stb_pkg::OP_TICK: begin
								res_q    <= '{status: stb_pkg::ST_OK, data: 32'd0};
								uptime_q <= uptime_q + 32'd1;
								cnt_q    <= '0;
								wr_go_s1 <= 1'b0;
								state_q  <= S_TICK;
							end
							stb_pkg::OP_ALLOCATE: begin
								res_q   <= '{status: stb_pkg::ST_OK, data: 32'd0};
								cnt_q   <= '0;
								state_q <= S_ALLOC;
							end
							stb_pkg::OP_UPTIME: begin
								res_q   <= '{status: stb_pkg::ST_OK, data: uptime_q};
								state_q <= S_DONE;
							end
							stb_pkg::OP_READ: begin
								if (ch_ok) begin
									res_q   <= '{status: stb_pkg::ST_OK, data: 32'd0};
									state_q <= S_READ;
								end else begin
									res_q   <= '{status: stb_pkg::ST_BAD_CHANNEL, data: 32'd0};
									state_q <= S_DONE;
								end
							end
							stb_pkg::OP_ENABLE, stb_pkg::OP_DISABLE,
							stb_pkg::OP_CLEAR, stb_pkg::OP_WRITE: begin
								if (!ch_ok) begin
									res_q <= '{status: stb_pkg::ST_BAD_CHANNEL, data: 32'd0};
								end else begin
									res_q <= '{status: stb_pkg::ST_OK, data: 32'd0};
									if (req.op == stb_pkg::OP_ENABLE) begin
										enabled_q[ch_idx] <= 1'b1;
									end else if (req.op == stb_pkg::OP_DISABLE) begin
										enabled_q[ch_idx] <= 1'b0;
									end
								end
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_TICK: begin
					// read stage issues channel cnt_q, write stage finishes the one before
					wr_go_s1  <= !cnt_end;
					wr_idx_s1 <= cnt_idx;
					if (cnt_end) begin
						state_q <= S_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_ALLOC: begin
					if (cnt_end) begin
						res_q.status <= stb_pkg::ST_NO_FREE;
						state_q      <= S_DONE;
					end else if (!allocated_q[cnt_idx]) begin
						allocated_q[cnt_idx] <= 1'b1;
						res_q.data           <= 32'(cnt_q);
						state_q              <= S_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_READ: begin
					res_q.data <= 32'(rd_data);
					state_q    <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/stb_checker.sv =====
// port-level checks of the software timer bank, bound to the top level
// depends on stb_pkg and software_timer_bank_macros.svh
`include "software_timer_bank_macros.svh"

module stb_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input stb_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input stb_pkg::rsp_t rsp
);

	logic status_known;
	logic rsp_err;
	logic rsp_stall;

	assign status_known = (rsp.status == stb_pkg::ST_OK) ||
		(rsp.status == stb_pkg::ST_BAD_CHANNEL) || (rsp.status == stb_pkg::ST_NO_FREE);
	assign rsp_err   = rsp_valid && (rsp.status != stb_pkg::ST_OK);
	assign rsp_stall = rsp_valid && !rsp_ready;

	`STB_ASSERT_ALWAYS(a_rst_no_rsp, !arst_n |=> !rsp_valid, "response valid during reset")
	`STB_ASSERT(a_status_code, rsp_valid |-> status_known, "undefined status code")
	`STB_ASSERT(a_err_zero_data, rsp_err |-> (rsp.data == 32'd0), "error response with data")
	`STB_ASSERT(a_rsp_hold, rsp_stall |=> rsp_valid && $stable(rsp), "stalled response changed")

endmodule

bind software_timer_bank stb_checker u_stb_checker (.*);
